// ===== rtl/sra_pkg.sv =====
// Shared types, constants and field widths for the sector run allocator.
package sra_pkg;

  localparam int NUM_SECTORS_DEF   = 4096;
  localparam int MAP_WORD_BITS_DEF = 32;
  localparam int STEP_BITS         = 8;
  localparam int HINT_W            = 12;
  localparam int LEN_W             = 13;
  localparam int STATUS_W          = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED = 2'd0,
    ST_OVERLAP = 2'd1,
    ST_NOROOM  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CHK,
    S_MRD,
    S_MWR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic overlap;
    logic found;
  } chunk_flags_t;

endpackage

// ===== rtl/sra_map_mem.sv =====
// Allocation map memory with per-word valid bits and a registered read port.
module sra_map_mem #(
  parameter int WORDS = 128,
  parameter int WB    = 32,
  parameter int AW    = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [WB-1:0] wr_data,
  output logic [WB-1:0] rd_data
);
  import sra_pkg::*;

  logic [WB-1:0] mem [WORDS];
  logic [WORDS-1:0] vld_r;
  logic [WB-1:0] rdata_r;
  logic          rvld_r;

  // Words never written read as all free.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rvld_r <= vld_r[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  assign rd_data = rvld_r ? rdata_r : '0;

endmodule

// ===== rtl/sra_chunk_eval.sv =====
// Evaluates one eight-sector slice of the map for the hinted check or the first-fit search.
module sra_chunk_eval #(
  parameter int NS = 4096,
  parameter int CW = 14
) (
  input  logic                           hinted,
  input  logic [sra_pkg::STEP_BITS-1:0]  bits,
  input  logic [CW-1:0]                  base,
  input  logic [CW-1:0]                  hint,
  input  logic [CW-1:0]                  hint_end,
  input  logic [CW-1:0]                  len,
  input  logic [CW-1:0]                  cnt_in,
  output sra_pkg::chunk_flags_t          flags,
  output logic [CW-1:0]                  cnt_out,
  output logic [CW-1:0]                  found_start
);
  import sra_pkg::*;

  localparam logic [CW-1:0] NSV = CW'(NS);

  always_comb begin
    logic [CW-1:0] s;
    logic [CW-1:0] cnt;
    logic          ov;
    logic          fnd;
    logic [CW-1:0] fst;
    cnt = cnt_in;
    ov  = 1'b0;
    fnd = 1'b0;
    fst = '0;
    for (int k = 0; k < STEP_BITS; k++) begin
      s = base + CW'(k);
      if (s < NSV) begin
        // Hinted check: any used sector inside the run and the map.
        if (bits[k] && s >= hint && s < hint_end) begin
          ov = 1'b1;
        end
        // First fit: length of the free run ending at this sector.
        if (bits[k]) begin
          cnt = '0;
        end else begin
          cnt = cnt + CW'(1);
          if (!fnd && cnt == len) begin
            fnd = 1'b1;
            fst = s + CW'(1) - len;
          end
        end
      end
    end
    flags.overlap = hinted & ov;
    flags.found   = ~hinted & fnd;
    cnt_out       = cnt;
    found_start   = fst;
  end

endmodule

// ===== rtl/sector_run_allocator_unit.sv =====
// Top level of the sector run allocator: control sequencer, map memory and slice evaluator.
//
// The block hands out runs of contiguous sectors from a one-bit-per-sector
// allocation map. Each request transaction on the in_ channel carries a run
// length and, when in_tuser is high, a hinted start sector. The hinted run is
// granted only if all of its sectors are free and it fits in the map; without
// a hint the lowest free run that fits is found by a first-fit scan. Each
// request produces exactly one result transaction on the out_ channel with a
// status, the granted start sector and one past the highest sector in use.
// Requests are handled one at a time. The map is read one word per memory
// access; each word visited is read once and then evaluated in slices of
// eight sectors, and marking a granted run reads and writes back each word
// it touches before the result is loaded into the output register. After
// reset every sector is free, with no clearing pass: the map words carry
// valid bits. When the receiver stalls, the finished result waits in the
// output register and the block may take the next request; that request
// waits in its final state until the output register is free.
module sector_run_allocator_unit #(
  parameter int NUM_SECTORS   = sra_pkg::NUM_SECTORS_DEF,
  parameter int MAP_WORD_BITS = sra_pkg::MAP_WORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [31:0]                  in_tdata,   // [11:0] hint_sector, [24:12] run_length
  input  logic                         in_tuser,   // [0] use_hint
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [31:0]                  out_tdata,  // [11:0] start_sector, [24:12] highest_end
  output logic [sra_pkg::STATUS_W-1:0] out_tuser   // [1:0] status
);
  import sra_pkg::*;

  localparam int LW        = $clog2(MAP_WORD_BITS);
  localparam int MAP_WORDS = (NUM_SECTORS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int SW        = $clog2(NUM_SECTORS + 1);
  localparam int CW        = ((SW > LEN_W) ? SW : LEN_W) + 1;
  localparam logic [CW-1:0] NSV = CW'(NUM_SECTORS);

  state_t state_r, state_nxt;
  logic          hinted_r, hinted_nxt;
  logic [CW-1:0] hint_r, hint_nxt;
  logic [CW-1:0] len_r, len_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] start_r, start_nxt;
  logic [CW-1:0] end_r, end_nxt;
  logic [CW-1:0] used_end_r, used_end_nxt;
  status_t       status_r, status_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [31:0]   out_data_r, out_data_nxt;
  status_t       out_status_r, out_status_nxt;

  logic                 mem_rd_en, mem_wr_en;
  logic [AW-1:0]        word_addr;
  logic [MAP_WORD_BITS-1:0] rd_word, wr_word, mark_mask, word_sh;

  chunk_flags_t  flags;
  logic [CW-1:0] cnt_out, found_start;
  logic [CW-1:0] hint_end, hint_lim, pos_step, pos_word;
  logic [CW-1:0] in_hint, in_len;

  assign word_addr = pos_r[LW +: AW];
  assign word_sh   = rd_word >> pos_r[LW-1:0];
  assign hint_end  = hint_r + len_r;
  assign hint_lim  = (hint_end < NSV) ? hint_end : NSV;
  assign pos_step  = pos_r + CW'(STEP_BITS);
  assign pos_word  = pos_r + CW'(MAP_WORD_BITS);
  assign in_hint   = CW'(in_tdata[HINT_W-1:0]);
  assign in_len    = (in_tdata[HINT_W +: LEN_W] == '0) ? CW'(1) : CW'(in_tdata[HINT_W +: LEN_W]);

  sra_map_mem #(
    .WORDS (MAP_WORDS),
    .WB    (MAP_WORD_BITS),
    .AW    (AW)
  ) u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (mem_rd_en),
    .rd_addr (word_addr),
    .wr_en   (mem_wr_en),
    .wr_addr (word_addr),
    .wr_data (wr_word),
    .rd_data (rd_word)
  );

  sra_chunk_eval #(
    .NS (NUM_SECTORS),
    .CW (CW)
  ) u_eval (
    .hinted      (hinted_r),
    .bits        (word_sh[STEP_BITS-1:0]),
    .base        (pos_r),
    .hint        (hint_r),
    .hint_end    (hint_end),
    .len         (len_r),
    .cnt_in      (cnt_r),
    .flags       (flags),
    .cnt_out     (cnt_out),
    .found_start (found_start)
  );

  // Sectors of the granted run that fall in the word being written back.
  always_comb begin
    logic [CW-1:0] s;
    for (int j = 0; j < MAP_WORD_BITS; j++) begin
      s = pos_r + CW'(j);
      mark_mask[j] = (s >= start_r) && (s < end_r);
    end
  end

  assign wr_word   = rd_word | mark_mask;
  assign in_tready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_end_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_end_r  <= used_end_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hinted_r     <= hinted_nxt;
    hint_r       <= hint_nxt;
    len_r        <= len_nxt;
    pos_r        <= pos_nxt;
    cnt_r        <= cnt_nxt;
    start_r      <= start_nxt;
    end_r        <= end_nxt;
    status_r     <= status_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
  end

  always_comb begin
    logic [CW-1:0] new_end;
    state_nxt      = state_r;
    hinted_nxt     = hinted_r;
    hint_nxt       = hint_r;
    len_nxt        = len_r;
    pos_nxt        = pos_r;
    cnt_nxt        = cnt_r;
    start_nxt      = start_r;
    end_nxt        = end_r;
    status_nxt     = status_r;
    used_end_nxt   = used_end_r;
    out_valid_nxt  = out_valid_r & ~out_tready;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    mem_rd_en      = 1'b0;
    mem_wr_en      = 1'b0;
    new_end        = used_end_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          hinted_nxt = in_tuser;
          hint_nxt   = in_hint;
          len_nxt    = in_len;
          cnt_nxt    = '0;
          status_nxt = ST_NOROOM;
          if (in_tuser) begin
            pos_nxt   = {in_hint[CW-1:3], 3'b000};
            state_nxt = (in_hint >= NSV) ? S_DONE : S_RD;
          end else begin
            pos_nxt   = '0;
            state_nxt = (in_len > NSV) ? S_DONE : S_RD;
          end
        end
      end

      S_RD: begin
        mem_rd_en = 1'b1;
        state_nxt = S_CHK;
      end

      S_CHK: begin
        if (hinted_r) begin
          if (flags.overlap) begin
            status_nxt = ST_OVERLAP;
            state_nxt  = S_DONE;
          end else if (pos_step >= hint_lim) begin
            if (hint_end <= NSV) begin
              start_nxt = hint_r;
              end_nxt   = hint_end;
              pos_nxt   = {hint_r[CW-1:LW], LW'(0)};
              state_nxt = S_MRD;
            end else begin
              status_nxt = ST_NOROOM;
              state_nxt  = S_DONE;
            end
          end else begin
            pos_nxt   = pos_step;
            state_nxt = (pos_step[LW-1:0] == '0) ? S_RD : S_CHK;
          end
        end else begin
          cnt_nxt = cnt_out;
          if (flags.found) begin
            start_nxt = found_start;
            end_nxt   = found_start + len_r;
            pos_nxt   = {found_start[CW-1:LW], LW'(0)};
            state_nxt = S_MRD;
          end else if (pos_step >= NSV) begin
            status_nxt = ST_NOROOM;
            state_nxt  = S_DONE;
          end else begin
            pos_nxt   = pos_step;
            state_nxt = (pos_step[LW-1:0] == '0) ? S_RD : S_CHK;
          end
        end
      end

      S_MRD: begin
        mem_rd_en = 1'b1;
        state_nxt = S_MWR;
      end

      S_MWR: begin
        mem_wr_en = 1'b1;
        pos_nxt   = pos_word;
        if (pos_word >= end_r) begin
          status_nxt = ST_GRANTED;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_MRD;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          if (status_r == ST_GRANTED && end_r > used_end_r) begin
            new_end = end_r;
          end
          used_end_nxt   = new_end;
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_data_nxt   = {7'd0, new_end[LEN_W-1:0],
                            (status_r == ST_GRANTED) ? start_r[HINT_W-1:0] : HINT_W'(0)};
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

  // A granted run always ends above its start, so highest_end exceeds start_sector.
  a_grant_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == ST_GRANTED) |-> (out_tdata[24:12] > {1'b0, out_tdata[11:0]}))
    else $error("granted result with highest_end not above start_sector");

  // A refused request reports start sector zero.
  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != ST_GRANTED) |-> (out_tdata[11:0] == '0))
    else $error("refused result with nonzero start_sector");

  // An accepted request always leaves the idle state.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r != S_IDLE))
    else $error("accepted request did not start processing");

  // The map is written only while marking a granted run.
  a_write_in_mark: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr_en |-> (start_r < end_r && end_r <= NSV))
    else $error("map write outside a valid granted run");

endmodule
